// ----- rtl/lc2k_pkg.sv -----
// ----------------------------------------------------------------------------
// LC-2K step unit package
// Shared types, opcodes and field positions of the instruction step unit.
// ----------------------------------------------------------------------------
package lc2k_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ADDR_W    = 16;
    localparam int unsigned REG_COUNT = 8;
    localparam int unsigned REG_AW    = 3;

    localparam int unsigned OPC_LSB  = 22;
    localparam int unsigned REGA_LSB = 19;
    localparam int unsigned REGB_LSB = 16;
    localparam int unsigned DEST_LSB = 0;

    typedef enum logic [2:0] {
        OPC_ADD  = 3'd0,
        OPC_NOR  = 3'd1,
        OPC_LW   = 3'd2,
        OPC_SW   = 3'd3,
        OPC_BEQ  = 3'd4,
        OPC_JALR = 3'd5,
        OPC_HALT = 3'd6,
        OPC_NOOP = 3'd7
    } opcode_t;

    typedef enum logic {
        ITEM_LOAD = 1'b0,
        ITEM_STEP = 1'b1
    } item_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_MEMRD
    } state_t;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
    } rf_rd_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } rf_wr_t;

endpackage

// ----- rtl/lc2k_mem.sv -----
// ----------------------------------------------------------------------------
// LC-2K unified memory
// Single-port synchronous word memory with a registered read port.
// ----------------------------------------------------------------------------
module lc2k_mem #(
    parameter int unsigned MEM_WORDS = 65536
) (
    input  logic                      aclk,
    input  lc2k_pkg::mem_req_t        req,
    output logic [lc2k_pkg::WORD_W-1:0] rdata
);
    import lc2k_pkg::*;

    // MEM_WORDS is a power of two, so the index is the low address bits.
    localparam int unsigned AW = $clog2(MEM_WORDS);

    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic [AW-1:0]     idx;

    assign idx   = req.addr[AW-1:0];
    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[idx] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[idx];
        end
    end

endmodule

// ----- rtl/lc2k_rf.sv -----
// ----------------------------------------------------------------------------
// LC-2K register file
// Eight words, two registered read ports and one write port. Entries not yet
// written since reset read as zero.
// ----------------------------------------------------------------------------
module lc2k_rf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lc2k_pkg::rf_rd_t            rd,
    input  lc2k_pkg::rf_wr_t            wr,
    output logic [lc2k_pkg::WORD_W-1:0] a_data,
    output logic [lc2k_pkg::WORD_W-1:0] b_data
);
    import lc2k_pkg::*;

    logic [WORD_W-1:0]    regs [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [WORD_W-1:0]    a_reg;
    logic [WORD_W-1:0]    b_reg;

    assign a_data = a_reg;
    assign b_data = b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            regs[wr.addr] <= wr.data;
        end
        if (rd.rd_en) begin
            a_reg <= valid_reg[rd.ra] ? regs[rd.ra] : '0;
            b_reg <= valid_reg[rd.rb] ? regs[rd.rb] : '0;
        end
    end

endmodule

// ----- rtl/lc2k_instruction_step_unit.sv -----
// ----------------------------------------------------------------------------
// LC-2K instruction step unit
// Loads memory words and executes LC-2K instructions one at a time.
//
// Channel   Dir  Beat contents
// s_axis    in   tuser: op; tdata: load_address, load_word
// m_axis    out  tdata: next_pc, halted, executed_count, written_value
//
// A step runs through the idle (fetch), decode and execute states, a lw step
// also through the memory read state, set by the fetch, register read and
// data access through the single memory port. Loads and halted steps finish
// in idle. The input buffer refills once empty; one beat waits during a step.
// Reset clears the registers, pc, count and halt flag, not the memory.
// A stalled result holds the core at its final cycle with no side effects.
// ----------------------------------------------------------------------------
module lc2k_instruction_step_unit #(
    parameter int unsigned MEM_WORDS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // load_address[15:0], load_word[47:16]
    input  logic [0:0]  s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // next_pc[15:0], halted[16],
                                        // executed_count[48:17],
                                        // written_value[80:49], zero fill
);
    import lc2k_pkg::*;

    state_t state_reg, state_next;

    logic              ib_valid_reg;
    logic              ib_op_reg;
    logic [ADDR_W-1:0] ib_addr_reg;
    logic [WORD_W-1:0] ib_word_reg;

    logic [ADDR_W-1:0] pc_reg;
    logic [WORD_W-1:0] cnt_reg;
    logic              halt_reg;
    logic [WORD_W-1:0] instr_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_pc_reg;
    logic              out_halt_reg;
    logic [WORD_W-1:0] out_cnt_reg;
    logic [WORD_W-1:0] out_wv_reg;

    mem_req_t          mem_req;
    logic [WORD_W-1:0] mem_rdata;
    rf_rd_t            rf_rd;
    rf_wr_t            rf_wr;
    logic [WORD_W-1:0] rf_a;
    logic [WORD_W-1:0] rf_b;

    logic              slot_free;
    logic              ib_pop;
    logic              res_fire;
    logic              step_done;
    logic              halt_set;
    logic              instr_ld;
    logic [WORD_W-1:0] res_wv;
    logic [ADDR_W-1:0] npc;

    opcode_t           opc;
    logic [REG_AW-1:0] ra;
    logic [REG_AW-1:0] rb;
    logic [REG_AW-1:0] rd;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] pc1;
    logic [ADDR_W-1:0] daddr;
    logic [ADDR_W-1:0] br_tgt;

    lc2k_mem #(
        .MEM_WORDS(MEM_WORDS)
    ) u_mem (
        .aclk (aclk),
        .req  (mem_req),
        .rdata(mem_rdata)
    );

    lc2k_rf u_rf (
        .aclk   (aclk),
        .aresetn(aresetn),
        .rd     (rf_rd),
        .wr     (rf_wr),
        .a_data (rf_a),
        .b_data (rf_b)
    );

    assign opc    = opcode_t'(instr_reg[OPC_LSB +: 3]);
    assign ra     = instr_reg[REGA_LSB +: REG_AW];
    assign rb     = instr_reg[REGB_LSB +: REG_AW];
    assign rd     = instr_reg[DEST_LSB +: REG_AW];
    assign off    = instr_reg[ADDR_W-1:0];
    assign pc1    = pc_reg + 16'd1;
    assign daddr  = rf_a[ADDR_W-1:0] + off;
    assign br_tgt = pc1 + off;

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !ib_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_wv_reg, out_cnt_reg, out_halt_reg, out_pc_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ib_valid_reg && ib_op_reg == ITEM_STEP && !halt_reg) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (opc == OPC_LW) begin
                    state_next = ST_MEMRD;
                end else if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEMRD: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mem_req   = '0;
        rf_rd     = '0;
        rf_wr     = '0;
        ib_pop    = 1'b0;
        res_fire  = 1'b0;
        step_done = 1'b0;
        halt_set  = 1'b0;
        instr_ld  = 1'b0;
        res_wv    = '0;
        npc       = pc1;
        unique case (state_reg)
            ST_IDLE: begin
                if (ib_valid_reg) begin
                    if (ib_op_reg == ITEM_LOAD) begin
                        if (slot_free) begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = ib_addr_reg;
                            mem_req.wdata = ib_word_reg;
                            ib_pop        = 1'b1;
                            res_fire      = 1'b1;
                            res_wv        = ib_word_reg;
                        end
                    end else if (halt_reg) begin
                        if (slot_free) begin
                            ib_pop   = 1'b1;
                            res_fire = 1'b1;
                        end
                    end else begin
                        mem_req.re   = 1'b1;
                        mem_req.addr = pc_reg;
                        ib_pop       = 1'b1;
                    end
                end
            end
            ST_DECODE: begin
                instr_ld    = 1'b1;
                rf_rd.rd_en = 1'b1;
                rf_rd.ra    = mem_rdata[REGA_LSB +: REG_AW];
                rf_rd.rb    = mem_rdata[REGB_LSB +: REG_AW];
            end
            ST_EXEC: begin
                if (opc == OPC_LW) begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = daddr;
                end else if (slot_free) begin
                    res_fire  = 1'b1;
                    step_done = 1'b1;
                    unique case (opc)
                        OPC_ADD: begin
                            res_wv     = rf_a + rf_b;
                            rf_wr.en   = 1'b1;
                            rf_wr.addr = rd;
                            rf_wr.data = res_wv;
                        end
                        OPC_NOR: begin
                            res_wv     = ~(rf_a | rf_b);
                            rf_wr.en   = 1'b1;
                            rf_wr.addr = rd;
                            rf_wr.data = res_wv;
                        end
                        OPC_SW: begin
                            res_wv        = rf_b;
                            mem_req.we    = 1'b1;
                            mem_req.addr  = daddr;
                            mem_req.wdata = rf_b;
                        end
                        OPC_BEQ: begin
                            if (rf_a == rf_b) begin
                                npc = br_tgt;
                            end
                        end
                        OPC_JALR: begin
                            res_wv     = {16'd0, pc1};
                            rf_wr.en   = 1'b1;
                            rf_wr.addr = rb;
                            rf_wr.data = res_wv;
                            npc        = (ra == rb) ? pc1 : rf_a[ADDR_W-1:0];
                        end
                        OPC_HALT: begin
                            halt_set = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MEMRD: begin
                if (slot_free) begin
                    res_fire   = 1'b1;
                    step_done  = 1'b1;
                    res_wv     = mem_rdata;
                    rf_wr.en   = 1'b1;
                    rf_wr.addr = rb;
                    rf_wr.data = mem_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ib_valid_reg  <= 1'b0;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_axis_tvalid && s_axis_tready) begin
                ib_valid_reg <= 1'b1;
            end else if (ib_pop) begin
                ib_valid_reg <= 1'b0;
            end
            if (step_done) begin
                pc_reg   <= npc;
                cnt_reg  <= cnt_reg + 32'd1;
                halt_reg <= halt_reg | halt_set;
            end
            if (res_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            ib_op_reg   <= s_axis_tuser[0];
            ib_addr_reg <= s_axis_tdata[15:0];
            ib_word_reg <= s_axis_tdata[47:16];
        end
        if (instr_ld) begin
            instr_reg <= mem_rdata;
        end
        if (res_fire) begin
            out_pc_reg   <= step_done ? npc : pc_reg;
            out_halt_reg <= halt_reg | halt_set;
            out_cnt_reg  <= step_done ? cnt_reg + 32'd1 : cnt_reg;
            out_wv_reg   <= res_wv;
        end
    end

endmodule

// ----- rtl/lc2k_checker.sv -----
// ----------------------------------------------------------------------------
// LC-2K step unit checker
// Port-level checks on the result stream of the instruction step unit.
// ----------------------------------------------------------------------------
module lc2k_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    logic        m_beat;
    logic        seen_reg;
    logic        halt_seen_reg;
    logic [31:0] last_cnt_reg;

    assign m_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            halt_seen_reg <= 1'b0;
        end else if (m_beat) begin
            seen_reg      <= 1'b1;
            halt_seen_reg <= halt_seen_reg | m_axis_tdata[16];
        end
    end

    always_ff @(posedge aclk) begin
        if (m_beat) begin
            last_cnt_reg <= m_axis_tdata[48:17];
        end
    end

    // No result beat is offered in the cycle after a reset cycle.
    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid directly after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat dropped or changed");

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && halt_seen_reg |-> m_axis_tdata[16])
        else $error("halted flag cleared without reset");

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && seen_reg |->
            m_axis_tdata[48:17] == last_cnt_reg ||
            m_axis_tdata[48:17] == last_cnt_reg + 32'd1)
        else $error("executed count moved by more than one instruction");

    a_halted_count_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && halt_seen_reg |-> m_axis_tdata[48:17] == last_cnt_reg)
        else $error("instruction executed while halted");

endmodule

bind lc2k_instruction_step_unit lc2k_checker u_lc2k_checker (.*);
